### rtl/srgbxyz_pkg.sv
// shared types, matrix constants and the linearization table function
package srgbxyz_pkg;

    localparam int CODE_W  = 8;
    localparam int OUT_W   = 15;
    localparam int COEF_W  = 23;
    localparam int NUM_CH  = 3;
    localparam int TAB_LEN = 256;

    localparam logic [OUT_W-1:0] SAT_OUT = 15'h7fff;

    // matrix coefficients in q16, pre-scaled by 100
    localparam logic [COEF_W-1:0] COEF100 [NUM_CH][NUM_CH] = '{
        '{23'd2702700, 23'd2343600, 23'd1182900},
        '{23'd1393300, 23'd4687100, 23'd473200},
        '{23'd126500,  23'd781200,  23'd6229200}
    };

    typedef struct packed {
        logic [CODE_W-1:0] red;
        logic [CODE_W-1:0] green;
        logic [CODE_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [OUT_W-1:0] x_out;
        logic [OUT_W-1:0] y_out;
        logic [OUT_W-1:0] z_out;
    } xyz_t;

    // (x * y) >> 63
    function automatic logic [63:0] mul_q63(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[126:63];
    endfunction

    // a / b in q63, a <= b
    function automatic logic [63:0] div_q63(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = 64'd0;
        r = a;
        if (r >= b)
        begin
            q = 64'd1;
            r = r - b;
        end
        for (int i = 0; i < 63; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= b)
            begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] pow5_q63(input logic [63:0] m);
        logic [63:0] m2;
        m2 = mul_q63(m, m);
        return mul_q63(mul_q63(m2, m2), m);
    endfunction

    // round(lin(v) * 2^lb), saturated below 2^lb
    function automatic logic [63:0] lin_entry(input int unsigned v, input int unsigned lb);
        logic [63:0] full;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] t4;
        logic [63:0] t12;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] m;
        logic [63:0] res;
        full = 64'd1 << lb;
        if (v <= 10)
        begin
            res = (64'(10 * v) * full + 64'd16473) / 64'd32946;
        end
        else if (v >= 255)
        begin
            res = full - 64'd1;
        end
        else
        begin
            t   = div_q63(64'(1000 * v + 14025), 64'd269025);
            t2  = mul_q63(t, t);
            t4  = mul_q63(t2, t2);
            t12 = mul_q63(mul_q63(t4, t4), t4);
            lo  = 64'd0;
            hi  = full;
            for (int i = 0; i < 32; i++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi) >> 1;
                    m   = ((mid << 1) + 64'd1) << (62 - lb);
                    if (pow5_q63(m) > t12)
                        hi = mid;
                    else
                        lo = mid + 64'd1;
                end
            end
            res = (lo >= full) ? full - 64'd1 : lo;
        end
        return res;
    endfunction

endpackage

### rtl/srgbxyz_linearize.sv
// stage 1: per-channel gamma expansion through constant lookup tables
module srgbxyz_linearize
    import srgbxyz_pkg::*;
#(
    parameter int LINEAR_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pixel_t                 pix,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LINEAR_BITS-1:0] lin [NUM_CH]
);

    logic [LINEAR_BITS-1:0] lin_rom [TAB_LEN];
    logic                   valid_reg;
    logic [LINEAR_BITS-1:0] lin_reg [NUM_CH];
    logic [LINEAR_BITS-1:0] lin_next [NUM_CH];

    for (genvar g = 0; g < TAB_LEN; g++)
    begin : g_rom
        localparam logic [63:0] ENTRY = lin_entry(g, LINEAR_BITS);
        assign lin_rom[g] = ENTRY[LINEAR_BITS-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        lin_next[0] = lin_rom[pix.red];
        lin_next[1] = lin_rom[pix.green];
        lin_next[2] = lin_rom[pix.blue];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            lin_reg <= lin_next;
    end

    assign out_valid = valid_reg;
    assign lin       = lin_reg;

endmodule

### rtl/srgbxyz_matrix.sv
// stages 2 and 3: 3x3 coefficient products, then row sums
module srgbxyz_matrix
    import srgbxyz_pkg::*;
#(
    parameter int LINEAR_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [LINEAR_BITS-1:0]            lin [NUM_CH],
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [COEF_W+LINEAR_BITS+1:0]     sum [NUM_CH]
);

    localparam int PW = COEF_W + LINEAR_BITS;
    localparam int SW = PW + 2;

    logic          prod_valid_reg;
    logic          sum_valid_reg;
    logic          prod_ld;
    logic          sum_ld;
    logic [PW-1:0] prod_reg  [NUM_CH][NUM_CH];
    logic [PW-1:0] prod_next [NUM_CH][NUM_CH];
    logic [SW-1:0] sum_reg   [NUM_CH];
    logic [SW-1:0] sum_next  [NUM_CH];

    assign sum_ld   = !sum_valid_reg || out_ready;
    assign prod_ld  = !prod_valid_reg || sum_ld;
    assign in_ready = prod_ld;

    always_comb
    begin
        for (int r = 0; r < NUM_CH; r++)
        begin
            for (int c = 0; c < NUM_CH; c++)
                prod_next[r][c] = PW'(COEF100[r][c]) * PW'(lin[c]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_CH; r++)
            sum_next[r] = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ld)
                prod_valid_reg <= in_valid;
            if (sum_ld)
                sum_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ld && in_valid)
            prod_reg <= prod_next;
        if (sum_ld && prod_valid_reg)
            sum_reg <= sum_next;
    end

    assign out_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

### rtl/srgbxyz_scale.sv
// stage 4: round to output units, saturate, output register
module srgbxyz_scale
    import srgbxyz_pkg::*;
#(
    parameter int LINEAR_BITS   = 16,
    parameter int OUT_FRAC_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [COEF_W+LINEAR_BITS+1:0] sum [NUM_CH],
    output logic                          out_valid,
    input  logic                          out_stall,
    output xyz_t                          out_word
);

    localparam int SW = COEF_W + LINEAR_BITS + 2;
    localparam int RW = SW + OUT_FRAC_BITS + 1;
    localparam int SH = 16 + LINEAR_BITS;

    logic             valid_reg;
    xyz_t             word_reg;
    xyz_t             word_next;
    logic [OUT_W-1:0] res [NUM_CH];

    always_comb
    begin
        logic [RW-1:0] scaled;
        logic [RW-1:0] q;
        for (int r = 0; r < NUM_CH; r++)
        begin
            scaled = (RW'(sum[r]) << OUT_FRAC_BITS) + (RW'(1) << (15 + LINEAR_BITS));
            q      = scaled >> SH;
            res[r] = (q > RW'(SAT_OUT)) ? SAT_OUT : q[OUT_W-1:0];
        end
        word_next.x_out = res[0];
        word_next.y_out = res[1];
        word_next.z_out = res[2];
    end

    assign in_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### rtl/srgb_to_xyz_pixel_converter.sv
// srgb to cie xyz (d65) converter top level: four-stage pipeline
// an accepted pixel word passes the linearize, product, row-sum and output registers in that order
// throughput: one word per cycle while xyz_stall is low; each stage holds its word under stall
// pix_stall rises only when all four stages hold a word and the output is stalled
// reset clears all stage valid bits; the gamma tables are built at elaboration
module srgb_to_xyz_pixel_converter
    import srgbxyz_pkg::*;
#(
    parameter int LINEAR_BITS   = 16,
    parameter int OUT_FRAC_BITS = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pix_valid,
    output logic   pix_stall,
    input  pixel_t pix,
    output logic   xyz_valid,
    input  logic   xyz_stall,
    output xyz_t   xyz
);

    logic                          lin_valid;
    logic                          lin_ready;
    logic                          pix_ready;
    logic                          sum_valid;
    logic                          sum_ready;
    logic [LINEAR_BITS-1:0]        lin [NUM_CH];
    logic [COEF_W+LINEAR_BITS+1:0] sum [NUM_CH];

    srgbxyz_linearize #(
        .LINEAR_BITS (LINEAR_BITS)
    ) u_linearize (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_valid),
        .in_ready  (pix_ready),
        .pix       (pix),
        .out_valid (lin_valid),
        .out_ready (lin_ready),
        .lin       (lin)
    );

    srgbxyz_matrix #(
        .LINEAR_BITS (LINEAR_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lin_valid),
        .in_ready  (lin_ready),
        .lin       (lin),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .sum       (sum)
    );

    srgbxyz_scale #(
        .LINEAR_BITS   (LINEAR_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .sum       (sum),
        .out_valid (xyz_valid),
        .out_stall (xyz_stall),
        .out_word  (xyz)
    );

    assign pix_stall = !pix_ready;

    // input stalls only when the whole pipeline is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (lin_valid && sum_valid && xyz_valid && xyz_stall))
        else $error("input stalled with a bubble in the pipeline");

    // a summed word moves into an empty output register
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && !xyz_valid) |=> xyz_valid)
        else $error("output register failed to take a waiting word");

    // luminance never exceeds the white point
    a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        xyz_valid |-> ({17'd0, xyz.y_out} <= (32'd100 << OUT_FRAC_BITS)))
        else $error("y above white level");

endmodule

### verif/srgb_to_xyz_pixel_converter_checker.sv
// checker for the srgb to xyz converter: predicts each xyz word and compares it
`timescale 1ns / 1ps

module srgb_to_xyz_pixel_converter_checker
    import srgbxyz_pkg::*;
#(
    parameter int LIN_BITS  = 16,
    parameter int FRAC_BITS = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pix_valid,
    input  logic   pix_stall,
    input  pixel_t pix,
    input  logic   xyz_valid,
    input  logic   xyz_stall,
    input  xyz_t   xyz,
    output int     fail_count,
    output int     pending
);

    localparam longint unsigned OUT_MAX = 64'd32767;

    longint unsigned gamma_lut [256];
    longint unsigned d65_matrix [3][3];
    xyz_t            xyz_due [$];

    // (x * y) >> 63, kept to 64 bits
    function automatic logic [63:0] q63_product(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] wide;
        wide = {64'd0, x} * {64'd0, y};
        return wide[126:63];
    endfunction

    function automatic logic [63:0] q63_fifth(input logic [63:0] m);
        logic [63:0] sq;
        sq = q63_product(m, m);
        return q63_product(q63_product(sq, sq), m);
    endfunction

    function automatic longint unsigned decode_gamma(input int unsigned code);
        logic [63:0]  full;
        logic [127:0] num;
        logic [63:0]  t;
        logic [63:0]  t2;
        logic [63:0]  t4;
        logic [63:0]  t12;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  cand;
        logic [63:0]  lin;
        full = 64'd1 << LIN_BITS;
        if (code <= 10)
        begin
            lin = (64'(10 * code) * full + 64'd16473) / 64'd32946;
        end
        else if (code >= 255)
        begin
            lin = full - 64'd1;
        end
        else
        begin
            // t = (code/255 + 0.055) / 1.055 in q63
            num = 128'(1000 * code + 14025) << 63;
            t   = 64'(num / 128'd269025);
            t2  = q63_product(t, t);
            t4  = q63_product(t2, t2);
            t12 = q63_product(q63_product(t4, t4), t4);
            // smallest y whose upper rounding bound, raised to the fifth, exceeds t^12
            lo = 64'd0;
            hi = full;
            while (lo < hi)
            begin
                mid  = (lo + hi) >> 1;
                cand = ((mid << 1) + 64'd1) << (62 - LIN_BITS);
                if (q63_fifth(cand) > t12)
                    hi = mid;
                else
                    lo = mid + 64'd1;
            end
            lin = (lo >= full) ? full - 64'd1 : lo;
        end
        return lin;
    endfunction

    function automatic xyz_t predict_xyz(input pixel_t p);
        longint unsigned lin [3];
        longint unsigned acc;
        longint unsigned scaled;
        logic [OUT_W-1:0] chan [3];
        xyz_t res;
        lin[0] = gamma_lut[p.red];
        lin[1] = gamma_lut[p.green];
        lin[2] = gamma_lut[p.blue];
        for (int row = 0; row < 3; row++)
        begin
            acc = 0;
            for (int col = 0; col < 3; col++)
                acc = acc + d65_matrix[row][col] * lin[col];
            scaled = ((64'd100 * acc) << FRAC_BITS) + (64'd1 << (15 + LIN_BITS));
            scaled = scaled >> (16 + LIN_BITS);
            if (scaled > OUT_MAX)
                scaled = OUT_MAX;
            chan[row] = scaled[OUT_W-1:0];
        end
        res.x_out = chan[0];
        res.y_out = chan[1];
        res.z_out = chan[2];
        return res;
    endfunction

    initial
    begin
        d65_matrix[0][0] = 27027;
        d65_matrix[0][1] = 23436;
        d65_matrix[0][2] = 11829;
        d65_matrix[1][0] = 13933;
        d65_matrix[1][1] = 46871;
        d65_matrix[1][2] = 4732;
        d65_matrix[2][0] = 1265;
        d65_matrix[2][1] = 7812;
        d65_matrix[2][2] = 62292;
        for (int v = 0; v < 256; v++)
            gamma_lut[v] = decode_gamma(v);
    end

    always @(posedge clk)
    begin : watch
        xyz_t due;
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
                xyz_due.push_back(predict_xyz(pix));
            if (xyz_valid && !xyz_stall)
            begin
                if (xyz_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected xyz word x=%0d y=%0d z=%0d", $realtime,
                                 xyz.x_out, xyz.y_out, xyz.z_out);
                end
                else
                begin
                    due = xyz_due.pop_front();
                    if (due.x_out !== xyz.x_out || due.y_out !== xyz.y_out ||
                        due.z_out !== xyz.z_out)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: xyz mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                     $realtime, due.x_out, due.y_out, due.z_out,
                                     xyz.x_out, xyz.y_out, xyz.z_out);
                    end
                end
            end
            pending = xyz_due.size();
        end
    end

endmodule

### verif/srgb_to_xyz_pixel_converter_test.sv
// testbench top for the srgb to xyz converter: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module srgb_to_xyz_pixel_converter_test
    import srgbxyz_pkg::*;
();

    localparam int RANDOM_ITEMS = 1930;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 20;

    logic   clk;
    logic   rst_n;
    logic   pix_valid;
    logic   pix_stall;
    pixel_t pix;
    logic   xyz_valid;
    logic   xyz_stall;
    xyz_t   xyz;
    int     fail_count;
    int     pending;
    int     hold_req;

    srgb_to_xyz_pixel_converter i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .xyz_valid (xyz_valid),
        .xyz_stall (xyz_stall),
        .xyz       (xyz)
    );

    srgb_to_xyz_pixel_converter_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .xyz_valid  (xyz_valid),
        .xyz_stall  (xyz_stall),
        .xyz        (xyz),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("srgb_to_xyz_pixel_converter regression: fail");
        $finish;
    end

    function automatic logic [CODE_W-1:0] random_code();
        logic [CODE_W-1:0] code;
        case ($urandom_range(0, 15))
            0:       code = 8'd0;
            1:       code = 8'd255;
            2:       code = 8'd10;
            3:       code = 8'd11;
            4:       code = 8'(254 - $urandom_range(0, 1) * 253);
            default: code = 8'($urandom_range(0, 255));
        endcase
        return code;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p.red   = random_code();
        p.green = random_code();
        p.blue  = random_code();
        return p;
    endfunction

    function automatic pixel_t corner_pixel(input int idx);
        pixel_t p;
        case (idx)
            0:       p = '{8'd0,   8'd0,   8'd0};
            1:       p = '{8'd255, 8'd255, 8'd255};
            2:       p = '{8'd255, 8'd0,   8'd0};
            3:       p = '{8'd0,   8'd255, 8'd0};
            4:       p = '{8'd0,   8'd0,   8'd255};
            5:       p = '{8'd10,  8'd10,  8'd10};
            6:       p = '{8'd11,  8'd11,  8'd11};
            7:       p = '{8'd10,  8'd11,  8'd12};
            8:       p = '{8'd1,   8'd2,   8'd3};
            9:       p = '{8'd254, 8'd254, 8'd254};
            10:      p = '{8'd254, 8'd255, 8'd253};
            11:      p = '{8'd128, 8'd128, 8'd128};
            12:      p = '{8'd170, 8'd85,  8'd170};
            13:      p = '{8'd85,  8'd170, 8'd85};
            14:      p = '{8'd255, 8'd255, 8'd0};
            15:      p = '{8'd0,   8'd255, 8'd255};
            16:      p = '{8'd255, 8'd0,   8'd255};
            17:      p = '{8'd11,  8'd0,   8'd255};
            18:      p = '{8'd9,   8'd200, 8'd1};
            default: p = '{8'd127, 8'd64,  8'd32};
        endcase
        return p;
    endfunction

    // offer one word and hold it until accepted; returns at a falling edge
    task automatic send_pixel(input pixel_t p);
        pix       <= p;
        pix_valid <= 1'b1;
        do
            @(posedge clk);
        while (pix_stall);
        @(negedge clk);
    endtask

    task automatic idle_for(input int cycles);
        pix_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        pix_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // receiver: stall pattern changes mode now and then, long hold-off on request
    initial
    begin : receiver
        int mode;
        int left;
        int hold_seen;
        xyz_stall = 1'b0;
        mode      = 0;
        left      = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                xyz_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0:       xyz_stall <= 1'b0;
                1:       xyz_stall <= ($urandom_range(0, 99) < 25);
                2:       xyz_stall <= ($urandom_range(0, 99) < 75);
                default: xyz_stall <= ~xyz_stall;
            endcase
        end
    end

    initial
    begin : stimulus
        int sent;
        int burst;
        int gap;
        bit drained_once;
        rst_n        = 1'b0;
        pix_valid    = 1'b0;
        pix          = '0;
        sent         = 0;
        drained_once = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 20; i++)
            send_pixel(corner_pixel(i));
        wait_drained();

        // long receiver hold while the sender keeps offering
        hold_req++;
        for (int i = 0; i < 40; i++)
            send_pixel(random_pixel());

        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 32);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_pixel(random_pixel());
                sent++;
            end
            if (!drained_once && sent >= RANDOM_ITEMS / 2)
            begin
                drained_once = 1'b1;
                wait_drained();
            end
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                    idle_for(gap);
            end
            if ($urandom_range(0, 29) == 0)
                hold_req++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("srgb_to_xyz_pixel_converter regression: pass");
        else
            $display("srgb_to_xyz_pixel_converter regression: fail");
        $finish;
    end

endmodule
